>>> sv/ffa_pkg.sv
package ffa_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int HEADER_BYTES_DEF = 20;
    localparam int SPLIT_SLACK_DEF  = 16;

    localparam logic [31:0] HEAP_BASE_RST  = 32'h0100_0000;
    localparam logic [31:0] HEAP_BYTES_RST = 32'h0100_0000;

    // request modes
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_INIT  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_READY   = 3'd1;
    localparam logic [2:0] ST_NO_MEMORY   = 3'd2;
    localparam logic [2:0] ST_BAD_ADDRESS = 3'd3;
    localparam logic [2:0] ST_DOUBLE_FREE = 3'd4;

    // configuration register indexes
    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_BYTES = 1'b1;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_INIT,
        CMD_TAKE,
        CMD_SPLIT,
        CMD_FREE,
        CMD_MERGE
    } cmd_op_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        free;
    } seg_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [31:0] need;
        logic [31:0] base;
        logic [31:0] bytes;
    } cell_cmd_t;

    typedef struct packed {
        logic        hit;
        logic        split_ok;
        logic        mok;
        logic        free;
        logic [31:0] start;
    } cell_flag_t;

endpackage

>>> sv/first_fit_heap_allocator.sv
// First-fit heap allocator with coalescing of free neighbors.
// Input channel (in_valid/in_ready): one word carries mode, request_bytes
// and block_address. Mode allocate returns the data address of the first
// free segment large enough for the request rounded up to 8 bytes; mode
// free releases a block and merges it with free neighbors; mode init
// builds one free segment from heap_base/heap_bytes.
// Output channel (out_valid/out_ready): one word per input word, with
// result_address and status.
// Configuration: cfg_write/cfg_index/cfg_data, to be written by the user
// only while the block is idle; the block itself does not enforce this.
// The values are used at the next init. Allocate walks the segment cells
// one per cycle until it finds a fit; free walks the same way, then merges
// the freed segment with its free left and right neighbors.
// One request is in work at a time; the rate is set by the cell walk.
// Reset clears the segment count and the ready flag; allocate or free
// before the first init returns not ready. A stalled receiver holds the
// finished word in the output register while the block accepts the next
// input word; that word's result waits until the register is taken.
module first_fit_heap_allocator #(
    parameter int MAX_SEGMENTS = ffa_pkg::MAX_SEGMENTS_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
    parameter int SPLIT_SLACK  = ffa_pkg::SPLIT_SLACK_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] request_bytes,
    input  logic [31:0] block_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_address,
    output logic [2:0]  status,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    ffa_pkg::cell_cmd_t  cmd;
    ffa_pkg::cell_flag_t flag_sel;
    ffa_pkg::seg_t       segs   [MAX_SEGMENTS];
    ffa_pkg::seg_t       shifts [MAX_SEGMENTS];
    ffa_pkg::cell_flag_t flags  [MAX_SEGMENTS];
    logic [CW-1:0]       pos;
    logic [CW-1:0]       count;

    ffa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .HEADER_BYTES (HEADER_BYTES),
        .CW           (CW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .request_bytes  (request_bytes),
        .block_address  (block_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_address (result_address),
        .status         (status),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .pos            (pos),
        .count          (count),
        .flag           (flag_sel)
    );

    // Row of segment cells; cell i holds table entry i. Splits shift the
    // entries above the chosen one up a cell, merges shift them down.
    for (genvar i = 0; i < MAX_SEGMENTS; i++)
    begin : g_cell
        ffa_pkg::seg_t left_in;
        ffa_pkg::seg_t right_in;

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_mid_l
            assign left_in = shifts[i-1];
        end

        if (i == MAX_SEGMENTS - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_r
            assign right_in = segs[i+1];
        end

        ffa_cell #(
            .IDX          (i),
            .CW           (CW),
            .HEADER_BYTES (HEADER_BYTES),
            .SPLIT_SLACK  (SPLIT_SLACK)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (pos),
            .count      (count),
            .left_shift (left_in),
            .right_seg  (right_in),
            .seg        (segs[i]),
            .shift_out  (shifts[i]),
            .flag       (flags[i])
        );
    end

    // Only the cell at the walk position drives nonzero flags; OR them.
    always_comb
    begin
        flag_sel = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++)
            flag_sel = ffa_pkg::cell_flag_t'(flag_sel | flags[i]);
    end

endmodule

>>> sv/ffa_cell.sv
module ffa_cell #(
    parameter int IDX          = 0,
    parameter int CW           = 7,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
    parameter int SPLIT_SLACK  = ffa_pkg::SPLIT_SLACK_DEF
) (
    input  logic               clk,
    input  ffa_pkg::cell_cmd_t cmd,
    input  logic [CW-1:0]      pos,
    input  logic [CW-1:0]      count,
    input  ffa_pkg::seg_t      left_shift,
    input  ffa_pkg::seg_t      right_seg,
    output ffa_pkg::seg_t      seg,
    output ffa_pkg::seg_t      shift_out,
    output ffa_pkg::cell_flag_t flag
);

    localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
    localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);
    localparam logic [31:0]   H32      = 32'(HEADER_BYTES);
    localparam logic [31:0]   S32      = 32'(SPLIT_SLACK);

    ffa_pkg::seg_t seg_reg;
    ffa_pkg::seg_t seg_next;
    ffa_pkg::seg_t split_seg;
    logic          at_pos;
    logic          after_pos;
    logic [33:0]   merge_sum;
    logic [31:0]   merge_size;
    logic [33:0]   split_need;
    logic [31:0]   init_size;
    logic          right_valid;

    assign at_pos      = (pos == MY_IDX);
    assign after_pos   = (pos < MY_IDX);
    assign right_valid = (NEXT_IDX < count);

    assign merge_sum  = {2'b00, seg_reg.size} + {2'b00, H32} + {2'b00, right_seg.size};
    assign merge_size = (|merge_sum[33:32]) ? 32'hFFFF_FFFF : merge_sum[31:0];
    assign split_need = {2'b00, cmd.need} + {2'b00, H32} + {2'b00, S32};
    assign init_size  = (cmd.bytes > H32) ? (cmd.bytes - H32) : 32'd0;

    // remainder left behind by a split
    assign split_seg.start = seg_reg.start + H32 + cmd.need;
    assign split_seg.size  = seg_reg.size - cmd.need - H32;
    assign split_seg.free  = 1'b1;

    assign shift_out = at_pos ? split_seg : seg_reg;
    assign seg       = seg_reg;

    always_comb
    begin
        flag = '0;
        if (at_pos)
        begin
            flag.hit      = seg_reg.free && (seg_reg.size >= cmd.need);
            flag.split_ok = ({2'b00, seg_reg.size} >= split_need);
            flag.mok      = seg_reg.free && right_valid && right_seg.free;
            flag.free     = seg_reg.free;
            flag.start    = seg_reg.start;
        end
    end

    always_comb
    begin
        seg_next = seg_reg;
        case (cmd.op)
            ffa_pkg::CMD_INIT:
            begin
                if (MY_IDX == '0)
                begin
                    seg_next.start = cmd.base;
                    seg_next.size  = init_size;
                    seg_next.free  = 1'b1;
                end
            end
            ffa_pkg::CMD_TAKE:
            begin
                if (at_pos)
                    seg_next.free = 1'b0;
            end
            ffa_pkg::CMD_SPLIT:
            begin
                if (at_pos)
                begin
                    seg_next.size = cmd.need;
                    seg_next.free = 1'b0;
                end
                else if (after_pos)
                    seg_next = left_shift;
            end
            ffa_pkg::CMD_FREE:
            begin
                if (at_pos)
                    seg_next.free = 1'b1;
            end
            ffa_pkg::CMD_MERGE:
            begin
                if (at_pos)
                    seg_next.size = merge_size;
                else if (after_pos)
                    seg_next = right_seg;
            end
            default:
            begin
                seg_next = seg_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
    end

endmodule

>>> sv/ffa_ctrl.sv
module ffa_ctrl #(
    parameter int MAX_SEGMENTS = ffa_pkg::MAX_SEGMENTS_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
    parameter int CW           = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          mode,
    input  logic [31:0]         request_bytes,
    input  logic [31:0]         block_address,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         result_address,
    output logic [2:0]          status,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data,
    output ffa_pkg::cell_cmd_t  cmd,
    output logic [CW-1:0]       pos,
    output logic [CW-1:0]       count,
    input  ffa_pkg::cell_flag_t flag
);

    localparam logic [31:0]   H32     = 32'(HEADER_BYTES);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN_A = 5'b00010,
        S_SCAN_F = 5'b00100,
        S_MERGE  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ready_reg, ready_next;
    logic          back_reg, back_next;
    logic [31:0]   need_reg, need_next;
    logic [31:0]   addr_reg, addr_next;
    logic [31:0]   base_reg, bytes_reg;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [2:0]    res_st_reg, res_st_next;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_addr_reg;
    logic [2:0]    out_st_reg;
    logic          load_out;
    logic [32:0]   need_round;

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign result_address = out_addr_reg;
    assign status         = out_st_reg;
    assign pos            = pos_reg;
    assign count          = cnt_reg;
    assign need_round     = ({1'b0, request_bytes} + 33'd7) & ~33'd7;
    assign load_out       = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        ready_next    = ready_reg;
        back_next     = back_reg;
        need_next     = need_reg;
        addr_next     = addr_reg;
        res_addr_next = res_addr_reg;
        res_st_next   = res_st_reg;
        cmd.op        = ffa_pkg::CMD_NONE;
        cmd.need      = need_reg;
        cmd.base      = base_reg;
        cmd.bytes     = bytes_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_addr_next = 32'd0;
                    res_st_next   = ffa_pkg::ST_NOT_READY;
                    pos_next      = '0;
                    back_next     = 1'b0;
                    state_next    = S_DONE;
                    case (mode)
                        ffa_pkg::MODE_INIT:
                        begin
                            cmd.op      = ffa_pkg::CMD_INIT;
                            cnt_next    = CW'(1);
                            ready_next  = 1'b1;
                            res_st_next = ffa_pkg::ST_OK;
                        end
                        ffa_pkg::MODE_ALLOC:
                        begin
                            if (ready_reg && request_bytes != 32'd0)
                            begin
                                if (need_round[32])
                                    res_st_next = ffa_pkg::ST_NO_MEMORY;
                                else
                                begin
                                    need_next  = need_round[31:0];
                                    state_next = S_SCAN_A;
                                end
                            end
                        end
                        ffa_pkg::MODE_FREE:
                        begin
                            if (ready_reg)
                            begin
                                addr_next  = block_address;
                                state_next = S_SCAN_F;
                            end
                        end
                        default:
                        begin
                            res_st_next = ffa_pkg::ST_NOT_READY;
                        end
                    endcase
                end
            end
            S_SCAN_A:
            begin
                if (pos_reg >= cnt_reg)
                begin
                    res_st_next = ffa_pkg::ST_NO_MEMORY;
                    state_next  = S_DONE;
                end
                else if (flag.hit)
                begin
                    if (flag.split_ok && cnt_reg < CNT_MAX)
                    begin
                        cmd.op   = ffa_pkg::CMD_SPLIT;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                        cmd.op = ffa_pkg::CMD_TAKE;
                    res_addr_next = flag.start + H32;
                    res_st_next   = ffa_pkg::ST_OK;
                    state_next    = S_DONE;
                end
                else
                    pos_next = pos_reg + CW'(1);
            end
            S_SCAN_F:
            begin
                if (pos_reg >= cnt_reg)
                begin
                    res_st_next = ffa_pkg::ST_BAD_ADDRESS;
                    state_next  = S_DONE;
                end
                else if (flag.start + H32 == addr_reg)
                begin
                    if (flag.free)
                    begin
                        res_st_next = ffa_pkg::ST_DOUBLE_FREE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.op      = ffa_pkg::CMD_FREE;
                        res_st_next = ffa_pkg::ST_OK;
                        state_next  = S_MERGE;
                        // check the left neighbor first
                        if (pos_reg != '0)
                        begin
                            pos_next  = pos_reg - CW'(1);
                            back_next = 1'b1;
                        end
                    end
                end
                else
                    pos_next = pos_reg + CW'(1);
            end
            S_MERGE:
            begin
                if (flag.mok)
                begin
                    cmd.op    = ffa_pkg::CMD_MERGE;
                    cnt_next  = cnt_reg - CW'(1);
                    back_next = 1'b0;
                end
                else if (back_reg)
                begin
                    pos_next  = pos_reg + CW'(1);
                    back_next = 1'b0;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            ready_reg     <= 1'b0;
            back_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= ffa_pkg::HEAP_BASE_RST;
            bytes_reg     <= ffa_pkg::HEAP_BYTES_RST;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            ready_reg     <= ready_next;
            back_reg      <= back_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                if (cfg_index == ffa_pkg::CFG_HEAP_BASE)
                    base_reg <= cfg_data;
                else if (cfg_index == ffa_pkg::CFG_HEAP_BYTES)
                    bytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg     <= need_next;
        addr_reg     <= addr_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
        if (load_out)
        begin
            out_addr_reg <= res_addr_reg;
            out_st_reg   <= res_st_reg;
        end
    end

endmodule

>>> sv/ffa_checker.sv
module ffa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result_address,
    input logic [2:0]  status
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(result_address) && $stable(status))
        else $error("stalled result word changed");

    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ffa_pkg::ST_OK |-> result_address == 32'd0)
        else $error("failed request returned an address");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while a request is in work");

endmodule

bind first_fit_heap_allocator ffa_checker u_ffa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_address (result_address),
    .status         (status)
);
